// ===== sv/servo_angle_ramp_defines.svh =====
// Assertion macros shared by the servo angle ramp RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SERVO_ANGLE_RAMP_DEFINES_SVH
`define SERVO_ANGLE_RAMP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("servo angle ramp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("servo angle ramp assertion failed");

`endif

// ===== sv/sar_pkg.sv =====
// Types, constants and helper functions for the servo angle ramp.
// No dependencies; sar_if and every module of the block import it.
`timescale 1ns / 1ps

package sar_pkg;

   localparam int unsigned SPEED_REGS  = 6;
   localparam int unsigned CLAW_SERVO  = 5;
   localparam int unsigned MAX_RESULTS = 6;

   localparam int unsigned TYPE_W  = 2;
   localparam int unsigned SERVO_W = 3;
   localparam int unsigned FIELD_W = 16;
   localparam int unsigned ANGLE_W = 8;
   localparam int unsigned SPEED_W = 5;
   localparam int unsigned DELAY_W = 14;
   localparam int unsigned CSR_W   = 3;

   typedef logic [ANGLE_W-1:0] angle_type;
   typedef logic [SPEED_W-1:0] speed_type;
   typedef logic [DELAY_W-1:0] delay_type;

   localparam angle_type CLAW_MAX    = 8'd65;
   localparam angle_type ANGLE_MAX   = 8'd180;
   localparam speed_type SPEED_RESET = 5'd11;
   localparam speed_type SPEED_MAX   = 5'd20;
   localparam speed_type STEP_BASE   = 5'd21;
   localparam delay_type STOP_DELAY  = 14'd9999;

   // Register index of speed_servo0; the other speeds follow in order.
   localparam logic [CSR_W-1:0] CSR_SPEED_BASE = 3'd0;

   typedef enum logic [TYPE_W-1:0] {
      REQ_MOVE = 2'd0,
      REQ_CLAW = 2'd1,
      REQ_TICK = 2'd2
   } req_kind_type;

   typedef struct packed {
      logic      start;
      logic      tick;
      logic      grant;
      angle_type goal;
      delay_type delay;
   } servo_ctl_type;

   typedef struct packed {
      angle_type position;
      logic      due;
   } servo_stat_type;

   function automatic delay_type step_delay(input speed_type speed);
      speed_type sp;
      sp = (speed > SPEED_MAX) ? SPEED_MAX : speed;
      if (sp == '0) begin
         return STOP_DELAY;
      end
      return DELAY_W'(STEP_BASE) - DELAY_W'(sp);
   endfunction

endpackage

// ===== sv/sar_if.sv =====
// Valid/ready channel interfaces for the servo angle ramp.
// Depends on sar_pkg for field widths.
`timescale 1ns / 1ps

interface sar_req_if import sar_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [TYPE_W-1:0]         req_type;
   logic [SERVO_W-1:0]        servo_index;
   logic signed [FIELD_W-1:0] target_angle;
   logic                      claw_open;
   logic signed [FIELD_W-1:0] claw_width;

   modport source (output valid, req_type, servo_index, target_angle, claw_open, claw_width,
                   input ready);
   modport sink (input valid, req_type, servo_index, target_angle, claw_open, claw_width,
                 output ready);
endinterface

interface sar_rsp_if import sar_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SERVO_W-1:0] out_servo;
   logic [ANGLE_W-1:0] servo_angle;
   logic               last_of_run;

   modport source (output valid, out_servo, servo_angle, last_of_run, input ready);
   modport sink (input valid, out_servo, servo_angle, last_of_run, output ready);
endinterface

// ===== sv/servo_angle_ramp.sv =====
// Servo angle ramp: keeps a position and goal for each servo and walks the
// position one degree per step toward the goal, one step every 21 - speed
// millisecond ticks (speed capped at 20; 9999 for speed 0). An item is taken
// in the cycle it is offered whenever the pending result set is empty or its
// last beat leaves in that cycle, and all servo state updates at that edge, so
// items that give at most one result stream at one per cycle while the result
// output is not held. The result set is registered in the sequencer, each beat
// then in its output register; a tick that steps k servos (k at most 6) keeps
// ready low until its last beat leaves, as one result register sends every beat.
// Depends on sar_pkg, sar_if, sar_fold, sar_channel, sar_drain and the defines header.
`timescale 1ns / 1ps
`include "servo_angle_ramp_defines.svh"

module servo_angle_ramp import sar_pkg::*; #(
   parameter int unsigned SERVO_COUNT = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_index,
   input  speed_type        csr_wdata,
   sar_req_if.sink          req_bus,
   sar_rsp_if.source        rsp_bus
);

   speed_type speed_ff [SPEED_REGS];

   req_kind_type           kind;
   logic                   accept;
   logic                   tick;
   logic                   claw_cmd;
   logic                   to_claw;
   angle_type              new_goal;
   logic [SERVO_COUNT-1:0] start_vec;
   logic [SERVO_COUNT-1:0] due_vec;
   logic [SERVO_COUNT-1:0] grant_vec;
   logic [SERVO_COUNT-1:0] emit_vec;
   angle_type              position [SERVO_COUNT];
   servo_ctl_type          ctl [SERVO_COUNT];
   servo_stat_type         stat [SERVO_COUNT];
   logic                   can_accept;
   logic                   drain_busy;

   always_ff @(posedge clock) begin
      for (int i = 0; i < SPEED_REGS; i++) begin
         if (reset) begin
            speed_ff[i] <= SPEED_RESET;
         end else if (csr_we && (csr_index == CSR_SPEED_BASE + CSR_W'(i))) begin
            speed_ff[i] <= csr_wdata;
         end
      end
   end

   assign kind          = req_kind_type'(req_bus.req_type);
   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = can_accept;
   assign tick          = accept && (kind == REQ_TICK);
   assign claw_cmd      = (kind == REQ_CLAW);
   assign to_claw       = claw_cmd || (req_bus.servo_index == SERVO_W'(CLAW_SERVO));

   sar_fold u_fold (
      .claw_cmd     (claw_cmd),
      .to_claw      (to_claw),
      .target_angle (req_bus.target_angle),
      .claw_open    (req_bus.claw_open),
      .claw_width   (req_bus.claw_width),
      .goal         (new_goal)
   );

   // A tick steps at most MAX_RESULTS servos; later due servos wait a tick.
   always_comb begin
      for (int s = 0; s < SERVO_COUNT; s++) begin
         start_vec[s] = accept &&
                        (((kind == REQ_MOVE) && (int'(req_bus.servo_index) == s)) ||
                         (claw_cmd && (s == CLAW_SERVO)));
         grant_vec[s] = due_vec[s] &&
                        ($countones(due_vec & ~({SERVO_COUNT{1'b1}} << s)) < MAX_RESULTS);
      end
      emit_vec = start_vec | (grant_vec & {SERVO_COUNT{tick}});
   end

   for (genvar s = 0; s < SERVO_COUNT; s++) begin : g_servo
      delay_type delay;

      if (s < SPEED_REGS) begin : g_reg
         assign delay = step_delay(speed_ff[s]);
      end else begin : g_fixed
         assign delay = step_delay(SPEED_RESET);
      end

      assign ctl[s].start = start_vec[s];
      assign ctl[s].tick  = tick;
      assign ctl[s].grant = grant_vec[s];
      assign ctl[s].goal  = new_goal;
      assign ctl[s].delay = delay;

      sar_channel #(
         .RESET_ANGLE ((s == CLAW_SERVO) ? CLAW_MAX : 8'd0)
      ) u_channel (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl[s]),
         .stat  (stat[s])
      );

      assign due_vec[s]  = stat[s].due;
      assign position[s] = stat[s].position;
   end

   sar_drain #(
      .SERVO_COUNT (SERVO_COUNT)
   ) u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_mask  (emit_vec),
      .position   (position),
      .rsp        (rsp_bus),
      .can_accept (can_accept),
      .busy       (drain_busy)
   );

   `SAR_ASSERT_SAME(a_tick_cap, clock, reset, tick, $countones(grant_vec) <= MAX_RESULTS)
   `SAR_ASSERT_SAME(a_one_start, clock, reset, accept, $onehot0(start_vec))
   `SAR_ASSERT_NEXT(a_emit_pending, clock, reset, accept && (emit_vec != '0), drain_busy)

endmodule

// ===== sv/sar_fold.sv =====
// Goal angle computation: folds and clamps a move target, or clamps a claw width.
// Depends on sar_pkg.
`timescale 1ns / 1ps

module sar_fold import sar_pkg::*; (
   input  logic                      claw_cmd,
   input  logic                      to_claw,
   input  logic signed [FIELD_W-1:0] target_angle,
   input  logic                      claw_open,
   input  logic signed [FIELD_W-1:0] claw_width,
   output angle_type                 goal
);

   // ceil(2^24 / 360); exact quotient for every magnitude below 2^15 + 180.
   localparam logic [FIELD_W-1:0] FOLD_RECIP = 16'd46604;

   logic signed [FIELD_W:0] shifted;
   logic                    neg;
   logic signed [FIELD_W:0] mag_s;
   logic [FIELD_W-1:0]      mag;
   logic [2*FIELD_W-1:0]    prod;
   logic [FIELD_W-1:0]      quot;
   logic [FIELD_W-1:0]      quot_span;
   logic [FIELD_W-1:0]      rem_full;
   logic [8:0]              rem;
   logic [9:0]              folded;
   logic [9:0]              limit;
   angle_type               move_goal;
   angle_type               width_clamped;
   angle_type               claw_goal;

   always_comb begin
      shifted = $signed({target_angle[FIELD_W-1], target_angle}) + $signed({9'd0, ANGLE_MAX});
      neg     = shifted[FIELD_W];
      mag_s   = neg ? -shifted : shifted;
      mag     = mag_s[FIELD_W-1:0];

      prod      = mag * FOLD_RECIP;
      quot      = FIELD_W'(prod[2*FIELD_W-1:24]);
      // 360 = 256 + 64 + 32 + 8
      quot_span = (quot << 8) + (quot << 6) + (quot << 5) + (quot << 3);
      rem_full  = mag - quot_span;
      rem       = rem_full[8:0];

      // The remainder keeps the sign of the dividend, so a negative sum lands
      // at 180 or more after the offset is taken back off.
      if (neg) begin
         folded = 10'(rem) + 10'(ANGLE_MAX);
      end else if (rem >= 9'(ANGLE_MAX)) begin
         folded = 10'(rem - 9'(ANGLE_MAX));
      end else begin
         folded = 10'(9'(ANGLE_MAX) - rem);
      end

      limit     = to_claw ? 10'(CLAW_MAX) : 10'(ANGLE_MAX);
      move_goal = (folded > limit) ? limit[ANGLE_W-1:0] : folded[ANGLE_W-1:0];

      if (claw_width[FIELD_W-1]) begin
         width_clamped = '0;
      end else if (claw_width > $signed({8'd0, CLAW_MAX})) begin
         width_clamped = CLAW_MAX;
      end else begin
         width_clamped = claw_width[ANGLE_W-1:0];
      end
      claw_goal = claw_open ? width_clamped : CLAW_MAX - width_clamped;

      goal = claw_cmd ? claw_goal : move_goal;
   end

endmodule

// ===== sv/sar_channel.sv =====
// State of one servo: position, goal, step countdown and moving flag.
// Depends on sar_pkg.
`timescale 1ns / 1ps

module sar_channel import sar_pkg::*; #(
   parameter angle_type RESET_ANGLE = 8'd0
) (
   input  logic           clock,
   input  logic           reset,
   input  servo_ctl_type  ctl,
   output servo_stat_type stat
);

   angle_type position_ff, position_in;
   angle_type goal_ff, goal_in;
   delay_type countdown_ff, countdown_in;
   logic      moving_ff, moving_in;
   angle_type stepped;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= RESET_ANGLE;
         goal_ff      <= RESET_ANGLE;
         countdown_ff <= '0;
         moving_ff    <= 1'b0;
      end else begin
         position_ff  <= position_in;
         goal_ff      <= goal_in;
         countdown_ff <= countdown_in;
         moving_ff    <= moving_in;
      end
   end

   always_comb begin
      position_in  = position_ff;
      goal_in      = goal_ff;
      countdown_in = countdown_ff;
      moving_in    = moving_ff;

      if (goal_ff > position_ff) begin
         stepped = position_ff + 8'd1;
      end else if (goal_ff < position_ff) begin
         stepped = position_ff - 8'd1;
      end else begin
         stepped = position_ff;
      end

      if (ctl.start) begin
         goal_in      = ctl.goal;
         countdown_in = ctl.delay;
         moving_in    = (ctl.goal != position_ff);
      end else if (ctl.tick && moving_ff) begin
         if (countdown_ff > DELAY_W'(1)) begin
            countdown_in = countdown_ff - DELAY_W'(1);
         end else if (ctl.grant) begin
            position_in = stepped;
            if (stepped == goal_ff) begin
               moving_in    = 1'b0;
               countdown_in = '0;
            end else begin
               countdown_in = ctl.delay;
            end
         end
         // A due servo that was not granted keeps its count of one.
      end
   end

   assign stat.position = position_ff;
   assign stat.due      = moving_ff && (countdown_ff <= DELAY_W'(1));

endmodule

// ===== sv/sar_drain.sv =====
// Result sequencer: holds the servos to report for the last item, sends one
// beat per cycle unless back-pressured, lowest first, via an output register.
// Depends on sar_pkg and sar_rsp_if.
`timescale 1ns / 1ps

module sar_drain import sar_pkg::*; #(
   parameter int unsigned SERVO_COUNT = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [SERVO_COUNT-1:0] load_mask,
   input  angle_type              position [SERVO_COUNT],
   sar_rsp_if.source              rsp,
   output logic                   can_accept,
   output logic                   busy
);

   localparam int unsigned IDX_W = $clog2(SERVO_COUNT);

   logic [SERVO_COUNT-1:0] mask_ff, mask_in;
   logic [SERVO_COUNT-1:0] rest;
   logic [IDX_W-1:0]       pick;
   logic                   out_free;
   logic                   advance;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SERVO_W-1:0] rsp_servo_ff;
   angle_type          rsp_angle_ff;
   logic               rsp_last_ff;

   always_comb begin
      pick = '0;
      for (int i = SERVO_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick = IDX_W'(i);
         end
      end
   end

   // Clearing the lowest set bit leaves the servos still to report.
   assign rest       = mask_ff & (mask_ff - 1'b1);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign advance    = (mask_ff != '0) && out_free;
   assign can_accept = (mask_ff == '0) || (out_free && (rest == '0));
   assign busy       = (mask_ff != '0);

   always_comb begin
      if (load) begin
         mask_in = load_mask;
      end else if (advance) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_servo_ff <= pick[SERVO_W-1:0];
         rsp_angle_ff <= position[pick];
         rsp_last_ff  <= (rest == '0);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_servo   = rsp_servo_ff;
   assign rsp.servo_angle = rsp_angle_ff;
   assign rsp.last_of_run = rsp_last_ff;

endmodule
